>>> src/rgb565_gradient_generator_unit_macros.svh
// Assertion macros shared by the gradient generator RTL
`ifndef RGB565_GRADIENT_GENERATOR_UNIT_MACROS_SVH
`define RGB565_GRADIENT_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset
`define RGBG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("rgbg: assertion failed");

// Check that a condition never holds outside reset
`define RGBG_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("rgbg: forbidden condition seen");

`else

`define RGBG_ASSERT(lbl, prop)
`define RGBG_ASSERT_NEVER(lbl, cond)

`endif

`endif

>>> src/rgbg_pkg.sv
// Types, constants and helpers of the RGB565 gradient generator
package rgbg_pkg;

  localparam int COLOR_W       = 16;
  localparam int STEP_W        = 6;
  localparam int CH_W          = 6;
  localparam int NUM_CH        = 3;
  localparam int CH_IDX_W      = 2;
  localparam int DIV_CNT_W     = 3;
  localparam int DEF_MAX_STEPS = 63;

  localparam int RED_LSB   = 11;
  localparam int GREEN_LSB = 5;
  localparam int RED_MASK   = 'h1F;
  localparam int GREEN_MASK = 'h3F;
  localparam int BLUE_MASK  = 'h1F;

  localparam logic [CH_IDX_W-1:0]  CH_RED   = 2'd0;
  localparam logic [CH_IDX_W-1:0]  CH_GREEN = 2'd1;
  localparam logic [CH_IDX_W-1:0]  CH_BLUE  = 2'd2;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(CH_W - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } rgbg_state_t;

  // Pull one channel out of a packed color, zero-extended to CH_W bits
  function automatic logic [CH_W-1:0] chan_of(input logic [COLOR_W-1:0]  c,
                                              input logic [CH_IDX_W-1:0] k);
    logic [CH_W-1:0] v;
    case (k)
      CH_RED:   v = CH_W'((c >> RED_LSB) & COLOR_W'(RED_MASK));
      CH_GREEN: v = CH_W'((c >> GREEN_LSB) & COLOR_W'(GREEN_MASK));
      default:  v = CH_W'(c & COLOR_W'(BLUE_MASK));
    endcase
    return v;
  endfunction

endpackage

>>> src/rgbg_in_if.sv
// Request channel: first color, final color and step count
interface rgbg_in_if import rgbg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] from_color;
  logic [COLOR_W-1:0] to_color;
  logic [STEP_W-1:0]  step_count;

  modport source (output valid, output from_color, output to_color,
                  output step_count, input ready);
  modport sink   (input valid, input from_color, input to_color,
                  input step_count, output ready);
endinterface

>>> src/rgbg_out_if.sv
// Result channel: one interpolated color per beat
interface rgbg_out_if import rgbg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] color;
  logic [STEP_W-1:0]  position;
  logic               last;

  modport source (output valid, output color, output position, output last,
                  input ready);
  modport sink   (input valid, input color, input position, input last,
                  output ready);
endinterface

>>> src/rgb565_gradient_generator_unit.sv
// Top level of the RGB565 gradient generator
//
//   channel   dir  beat contents                          handshake
//   in_chan   in   from_color, to_color, step_count       valid/ready
//   out_chan  out  color, position, last                  valid/ready
//
// A request with step count n > 0 is accepted in idle; then one shared 6-bit
// restoring divider forms |end-start|/n and its remainder for red, green and
// blue in turn (a load state, then 6 quotient bits each), then n+1 result
// beats follow, one per cycle while out_chan.ready is high. A zero step count
// skips the divider and emits the start color once. in_chan.ready is high only
// while idle; a stalled result beat holds. rst_n is synchronous and returns to idle.
`include "rgb565_gradient_generator_unit_macros.svh"

module rgb565_gradient_generator_unit import rgbg_pkg::*; #(
  parameter int MAX_STEPS = DEF_MAX_STEPS
) (
  input  logic      clk,
  input  logic      rst_n,
  rgbg_in_if.sink   in_chan,
  rgbg_out_if.source out_chan
);

  rgbg_state_t state_r, state_nxt;

  logic [COLOR_W-1:0]   start_r, start_nxt;
  logic [COLOR_W-1:0]   end_r, end_nxt;
  logic [STEP_W-1:0]    steps_r, steps_nxt;
  logic [STEP_W-1:0]    pos_r, pos_nxt;
  logic [CH_IDX_W-1:0]  ch_r, ch_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CH_W-1:0]      dvd_r, dvd_nxt;
  logic [CH_W-1:0]      rem_r, rem_nxt;
  logic [CH_W-1:0]      qd_r [NUM_CH];
  logic [CH_W-1:0]      qd_nxt [NUM_CH];
  logic [CH_W-1:0]      rd_r [NUM_CH];
  logic [CH_W-1:0]      rd_nxt [NUM_CH];
  logic [CH_W-1:0]      q_r [NUM_CH];
  logic [CH_W-1:0]      q_nxt [NUM_CH];
  logic [CH_W-1:0]      r_r [NUM_CH];
  logic [CH_W-1:0]      r_nxt [NUM_CH];

  logic                 in_ready;
  logic                 out_valid;
  logic                 in_acc;
  logic                 out_acc;
  logic                 last_w;
  logic                 rem_ok;
  logic [STEP_W-1:0]    steps_sat;
  logic [CH_W-1:0]      a_ch [NUM_CH];
  logic [CH_W-1:0]      b_ch [NUM_CH];
  logic                 neg_ch [NUM_CH];
  logic [CH_W-1:0]      mag_ch [NUM_CH];
  logic [CH_W-1:0]      val_ch [NUM_CH];
  logic [CH_W:0]        rem_try;
  logic                 q_bit;

  assign in_acc  = in_chan.valid && in_ready;
  assign out_acc = out_valid && out_chan.ready;
  assign last_w  = (pos_r == steps_r);

  // Clamp the step count to the configured maximum
  assign steps_sat = (in_chan.step_count > STEP_W'(MAX_STEPS)) ?
                     STEP_W'(MAX_STEPS) : in_chan.step_count;

  // Split held colors per channel; form sign and magnitude of the difference
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      a_ch[k]   = chan_of(start_r, CH_IDX_W'(k));
      b_ch[k]   = chan_of(end_r, CH_IDX_W'(k));
      neg_ch[k] = (b_ch[k] < a_ch[k]);
      mag_ch[k] = neg_ch[k] ? (a_ch[k] - b_ch[k]) : (b_ch[k] - a_ch[k]);
      val_ch[k] = neg_ch[k] ? (a_ch[k] - q_r[k]) : (a_ch[k] + q_r[k]);
    end
  end

  // One restoring divider step: shift in the next dividend bit, try subtract
  assign rem_try = {rem_r, dvd_r[CH_W-1]};
  assign q_bit   = (rem_try >= {1'b0, steps_r});

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (steps_sat == '0) ? ST_EMIT : ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = (ch_r == CH_BLUE) ? ST_EMIT : ST_LOAD;
        end
      end
      ST_EMIT: begin
        if (out_acc && last_w) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: in_ready  = 1'b1;
      ST_EMIT: out_valid = 1'b1;
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  // Datapath next values
  always_comb begin
    logic [CH_W:0] rsum;
    start_nxt = start_r;
    end_nxt   = end_r;
    steps_nxt = steps_r;
    pos_nxt   = pos_r;
    ch_nxt    = ch_r;
    cnt_nxt   = cnt_r;
    dvd_nxt   = dvd_r;
    rem_nxt   = rem_r;
    qd_nxt    = qd_r;
    rd_nxt    = rd_r;
    q_nxt     = q_r;
    r_nxt     = r_r;
    rsum      = '0;
    case (state_r)
      ST_IDLE: begin
        // Latch the request and clear the running quotients and remainders
        if (in_acc) begin
          start_nxt = in_chan.from_color;
          end_nxt   = in_chan.to_color;
          steps_nxt = steps_sat;
          pos_nxt   = '0;
          ch_nxt    = CH_RED;
          for (int k = 0; k < NUM_CH; k++) begin
            q_nxt[k] = '0;
            r_nxt[k] = '0;
          end
        end
      end
      ST_LOAD: begin
        // Load this channel's magnitude into the divider
        dvd_nxt = mag_ch[ch_r];
        rem_nxt = '0;
        cnt_nxt = '0;
      end
      ST_DIV: begin
        // Advance one quotient bit; store the per-step increments at the end
        rem_nxt = q_bit ? CH_W'(rem_try - {1'b0, steps_r}) : CH_W'(rem_try);
        dvd_nxt = {dvd_r[CH_W-2:0], q_bit};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          qd_nxt[ch_r] = {dvd_r[CH_W-2:0], q_bit};
          rd_nxt[ch_r] = rem_nxt;
          ch_nxt       = ch_r + 1'b1;
        end
      end
      ST_EMIT: begin
        // Step every channel by quotient and remainder of |diff|/n
        if (out_acc && !last_w) begin
          pos_nxt = pos_r + 1'b1;
          for (int k = 0; k < NUM_CH; k++) begin
            rsum = {1'b0, r_r[k]} + {1'b0, rd_r[k]};
            if (rsum >= {1'b0, steps_r}) begin
              r_nxt[k] = CH_W'(rsum - {1'b0, steps_r});
              q_nxt[k] = q_r[k] + qd_r[k] + 1'b1;
            end else begin
              r_nxt[k] = CH_W'(rsum);
              q_nxt[k] = q_r[k] + qd_r[k];
            end
          end
        end
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      start_r <= '0;
      end_r   <= '0;
      steps_r <= '0;
      pos_r   <= '0;
      ch_r    <= CH_RED;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      start_r <= start_nxt;
      end_r   <= end_nxt;
      steps_r <= steps_nxt;
      pos_r   <= pos_nxt;
      ch_r    <= ch_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Divider and accumulator registers
  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    qd_r  <= qd_nxt;
    rd_r  <= rd_nxt;
    q_r   <= q_nxt;
    r_r   <= r_nxt;
  end

  // Drive the channels
  assign in_chan.ready     = in_ready;
  assign out_chan.valid    = out_valid;
  assign out_chan.color    = {val_ch[CH_RED][4:0], val_ch[CH_GREEN][5:0],
                              val_ch[CH_BLUE][4:0]};
  assign out_chan.position = pos_r;
  assign out_chan.last     = last_w;

  // Running remainders stay below the step count
  assign rem_ok = (r_r[0] < steps_r) && (r_r[1] < steps_r) && (r_r[2] < steps_r);

  // Checks
  `RGBG_ASSERT_NEVER(a_ready_excl, in_chan.ready && out_chan.valid)
  `RGBG_ASSERT(a_pos_bound, out_chan.valid |-> (pos_r <= steps_r))
  `RGBG_ASSERT(a_last_idle, (out_acc && last_w) |=> in_chan.ready)
  `RGBG_ASSERT(a_rem_bound, (state_r == ST_EMIT && steps_r != '0) |-> rem_ok)

endmodule
